FILE: rtl/core/hbf_pkg.sv
`default_nettype none

package hbf_pkg;

	// shared arithmetic unit operations
	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_BOX_LENGTH_X = 3'd0;
	localparam logic [2:0] REG_BOX_LENGTH_Y = 3'd1;
	localparam logic [2:0] REG_BOX_LENGTH_Z = 3'd2;
	localparam logic [2:0] REG_BOX_HALF_X   = 3'd3;
	localparam logic [2:0] REG_BOX_HALF_Y   = 3'd4;
	localparam logic [2:0] REG_BOX_HALF_Z   = 3'd5;

	localparam logic [63:0] SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SMIN_MAG = 64'h8000_0000_0000_0000;

	// request to the arithmetic unit; a is the 128-bit dividend or first operand
	typedef struct packed {
		logic         start;
		logic [1:0]   op;
		logic [127:0] a;
		logic [63:0]  b;
	} alu_req_t;

	typedef struct packed {
		logic         done;
		logic         ovf;
		logic [127:0] res;
	} alu_rsp_t;

	typedef struct packed {
		logic [63:0] val;
		logic        sat;
	} clip_t;

	// magnitude and sign to two's complement, saturating
	function automatic clip_t clip_mag(input logic hi_nz, input logic [63:0] mag,
			input logic neg);
		logic [63:0] lim;
		clip_t c;
		lim = neg ? SMIN_MAG : SMAX;
		c.sat = hi_nz || (mag > lim);
		c.val = c.sat ? lim : mag;
		if (neg) begin
			c.val = 64'd0 - c.val;
		end
		return c;
	endfunction

	function automatic clip_t sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		clip_t c;
		s = a + b;
		c.sat = (a[63] == b[63]) && (s[63] != a[63]);
		c.val = c.sat ? (a[63] ? SMIN_MAG : SMAX) : s;
		return c;
	endfunction

	// virial component i is force[vir_f(i)] * d[vir_x(i)]
	function automatic logic [1:0] vir_f(input logic [2:0] i);
		logic [1:0] f;
		case (i)
			3'd0: f = 2'd0;
			3'd1: f = 2'd1;
			3'd2: f = 2'd1;
			default: f = 2'd2;
		endcase
		return f;
	endfunction

	function automatic logic [1:0] vir_x(input logic [2:0] i);
		logic [1:0] x;
		case (i)
			3'd0: x = 2'd0;
			3'd1: x = 2'd0;
			3'd2: x = 2'd1;
			3'd3: x = 2'd0;
			3'd4: x = 2'd1;
			default: x = 2'd2;
		endcase
		return x;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hbf_alu.sv
`default_nettype none

// Shared arithmetic unit: 64x64 multiply over four 32x32 partial products,
// 128/64 restoring divide at two quotient bits a cycle, 64-bit integer sqrt.
module hbf_alu import hbf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	localparam logic [4:0] MUL_LAST  = 5'd4;
	localparam logic [4:0] ITER_LAST = 5'd31;

	logic        busy_q, done_q, ovf_q;
	logic [1:0]  op_q;
	logic [4:0]  cnt_q;

	logic [63:0]  ma_q, mb_q, pp_q;
	logic [1:0]   psh_q;
	logic [127:0] acc_q;
	logic [63:0]  rem_q, dlo_q, quo_q, dvs_q;
	logic [63:0]  sv_q, sres_q, sbit_q;

	logic [31:0]  pa, pb;
	logic [63:0]  pp_next;
	logic [1:0]   psh_next;
	logic [127:0] pp_ext;
	logic [63:0]  rem_n, dlo_n, quo_n;
	logic [65:0]  trial;
	logic [63:0]  ssum, sv_n, sres_n;

	// partial product select
	always_comb begin
		pa = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		pb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
		pp_next = pa * pb;
		psh_next = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
		case (psh_q)
			2'd0: pp_ext = {64'd0, pp_q};
			2'd1: pp_ext = {32'd0, pp_q, 32'd0};
			default: pp_ext = {pp_q, 64'd0};
		endcase
	end

	// two restoring divide steps
	always_comb begin
		rem_n = rem_q;
		dlo_n = dlo_q;
		quo_n = quo_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {1'b0, rem_n, dlo_n[63]} - {2'b00, dvs_q};
			dlo_n = {dlo_n[62:0], 1'b0};
			quo_n = {quo_n[62:0], 1'b0};
			if (!trial[65]) begin
				rem_n = trial[63:0];
				quo_n[0] = 1'b1;
			end else begin
				rem_n = {rem_n[62:0], trial[0] ^ dvs_q[0] ^ 1'b0};
			end
		end
	end

	// one square root step
	always_comb begin
		ssum = sres_q + sbit_q;
		if (sv_q >= ssum) begin
			sv_n = sv_q - ssum;
			sres_n = (sres_q >> 1) + sbit_q;
		end else begin
			sv_n = sv_q;
			sres_n = sres_q >> 1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q <= 1'b0;
			op_q <= OP_MUL;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q <= req.op;
				cnt_q <= '0;
				ovf_q <= 1'b0;
				busy_q <= 1'b1;
				if (req.op == OP_DIV && req.a[127:64] >= req.b) begin
					ovf_q <= 1'b1;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if ((op_q == OP_MUL && cnt_q == MUL_LAST) ||
						(op_q != OP_MUL && cnt_q == ITER_LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q <= req.a[63:0];
			mb_q <= req.b;
			acc_q <= '0;
			rem_q <= req.a[127:64];
			dlo_q <= req.a[63:0];
			dvs_q <= req.b;
			quo_q <= '0;
			sv_q <= req.a[63:0];
			sres_q <= '0;
			sbit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					pp_q <= pp_next;
					psh_q <= psh_next;
					if (cnt_q != 5'd0) begin
						acc_q <= acc_q + pp_ext;
					end
				end
				OP_DIV: begin
					rem_q <= rem_n;
					dlo_q <= dlo_n;
					quo_q <= quo_n;
				end
				default: begin
					sv_q <= sv_n;
					sres_q <= sres_n;
					sbit_q <= sbit_q >> 2;
				end
			endcase
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.ovf = ovf_q;
		case (op_q)
			OP_MUL: rsp.res = acc_q;
			OP_DIV: rsp.res = {64'd0, quo_q};
			default: rsp.res = {64'd0, sres_q};
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/harmonic_bond_force_top.sv
// Channel  | Handshake                  | Payload
// cfg      | cfg_wr_en                  | cfg_index, cfg_data (box lengths, half lengths)
// in       | in_valid / in_stall        | pos_a_*, pos_b_*, stiffness, rest_length, last_bond
// out      | out_valid / out_stall      | kind, value_0..6, last_result, saturated
//
// A bond is worked through before the next one is accepted. Ten 128/64 divides
// at two bits a cycle dominate the shared unit. A 32-step sqrt and twenty
// 4-pass multiplies make up the rest. A zero-length bond skips every step
// after the energy. A divide whose quotient overflows ends without iterating.
// A last bond adds a totals item after its per-bond item.
// in_stall is high from acceptance until the per-bond (and totals) item is
// loaded into the output register; the output register may still hold an item.
// An output stall while the output register is full holds the sequencer in its load step for as long as it lasts.
// Reset clears the box registers, the energy and virial sums and the control.
`default_nettype none

module harmonic_bond_force_top import hbf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_a_x,
	input  logic signed [31:0] pos_a_y,
	input  logic signed [31:0] pos_a_z,
	input  logic signed [31:0] pos_b_x,
	input  logic signed [31:0] pos_b_y,
	input  logic signed [31:0] pos_b_z,
	input  logic [31:0]        stiffness,
	input  logic [31:0]        rest_length,
	input  logic               last_bond,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic signed [63:0] value_0,
	output logic signed [63:0] value_1,
	output logic signed [63:0] value_2,
	output logic signed [63:0] value_3,
	output logic signed [63:0] value_4,
	output logic signed [63:0] value_5,
	output logic signed [63:0] value_6,
	output logic               last_result,
	output logic               saturated
);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_WRAP  = 5'd1;
	localparam logic [4:0] ST_CLIP  = 5'd2;
	localparam logic [4:0] ST_SQ_I  = 5'd3;
	localparam logic [4:0] ST_SQ_W  = 5'd4;
	localparam logic [4:0] ST_RT_I  = 5'd5;
	localparam logic [4:0] ST_RT_W  = 5'd6;
	localparam logic [4:0] ST_KMD_I = 5'd7;
	localparam logic [4:0] ST_KMD_W = 5'd8;
	localparam logic [4:0] ST_EN_I  = 5'd9;
	localparam logic [4:0] ST_EN_W  = 5'd10;
	localparam logic [4:0] ST_DE_I  = 5'd11;
	localparam logic [4:0] ST_DE_W  = 5'd12;
	localparam logic [4:0] ST_FM_I  = 5'd13;
	localparam logic [4:0] ST_FM_W  = 5'd14;
	localparam logic [4:0] ST_FD_I  = 5'd15;
	localparam logic [4:0] ST_FD_W  = 5'd16;
	localparam logic [4:0] ST_T1M_I = 5'd17;
	localparam logic [4:0] ST_T1M_W = 5'd18;
	localparam logic [4:0] ST_T1D_I = 5'd19;
	localparam logic [4:0] ST_T1D_W = 5'd20;
	localparam logic [4:0] ST_T2M_I = 5'd21;
	localparam logic [4:0] ST_T2M_W = 5'd22;
	localparam logic [4:0] ST_T2D_I = 5'd23;
	localparam logic [4:0] ST_T2D_W = 5'd24;
	localparam logic [4:0] ST_VM_I  = 5'd25;
	localparam logic [4:0] ST_VM_W  = 5'd26;
	localparam logic [4:0] ST_OUT   = 5'd27;
	localparam logic [4:0] ST_TOT   = 5'd28;

	logic [4:0]  state_q;
	logic [2:0]  idx_q;
	logic [1:0]  ix;

	logic [30:0] box_len_q [3];
	logic [30:0] box_half_q [3];

	logic [63:0] energy_q;
	logic [63:0] vsum_q [6];
	logic        sums_clip_q;

	logic signed [33:0] d_q [3];
	logic [31:0] mx_q [3];
	logic        nx_q [3];
	logic [63:0] sq_q [3];
	logic [63:0] s_q;
	logic [31:0] k_q, req_q, r_q, md_q;
	logic        nd_q, last_q, sat_q;
	logic [63:0] kmd_q, de_q, t1_q;
	logic [127:0] prod_q;
	logic [63:0] force_q [3];
	logic [63:0] hess_q [3];

	logic        out_valid_q, kind_q, last_res_q, sat_out_q;
	logic [63:0] val_q [7];

	alu_req_t    alu_req;
	alu_rsp_t    alu_rsp;

	logic signed [31:0] pa [3];
	logic signed [31:0] pb [3];
	logic signed [33:0] dw [3];
	logic [31:0] mx_n [3];
	logic        nx_n [3];
	logic        clip_sat;
	logic [127:0] p;
	logic [32:0] rt_diff, rt_neg;
	clip_t       c_en, a_en, c_de, c_force, c_hess, c_vir, a_vir;
	logic [63:0] t2, hm;
	logic        hn;
	logic [63:0] vf, vmag;
	logic [1:0]  vxi;
	logic        out_free, accept, out_load;

	assign pa[0] = pos_a_x;
	assign pa[1] = pos_a_y;
	assign pa[2] = pos_a_z;
	assign pb[0] = pos_b_x;
	assign pb[1] = pos_b_y;
	assign pb[2] = pos_b_z;

	assign ix = idx_q[1:0];
	assign p = alu_rsp.res;
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_OUT || state_q == ST_TOT) && out_free;

	hbf_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// minimum image and clip to Q16.16 per axis
	always_comb begin
		logic signed [33:0] h, l, dc, dm;
		clip_sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			h = $signed({3'b000, box_half_q[i]});
			l = $signed({3'b000, box_len_q[i]});
			if (d_q[i] > h) begin
				dw[i] = d_q[i] - l;
			end else if (d_q[i] < -h) begin
				dw[i] = d_q[i] + l;
			end else begin
				dw[i] = d_q[i];
			end
			if (d_q[i] > 34'sd2147483647) begin
				dc = 34'sd2147483647;
				clip_sat = 1'b1;
			end else if (d_q[i] < -34'sd2147483648) begin
				dc = -34'sd2147483648;
				clip_sat = 1'b1;
			end else begin
				dc = d_q[i];
			end
			nx_n[i] = dc[33];
			dm = nx_n[i] ? -dc : dc;
			mx_n[i] = dm[31:0];
		end
	end

	// result shaping for each step
	always_comb begin
		rt_diff = {1'b0, p[31:0]} - {1'b0, req_q};
		rt_neg = 33'd0 - rt_diff;
		c_en = clip_mag(|p[127:80], p[79:16], 1'b0);
		a_en = sat_add(energy_q, c_en.val);
		c_de = clip_mag(alu_rsp.ovf, p[63:0], 1'b0);
		c_force = clip_mag(alu_rsp.ovf, p[63:0], nd_q == nx_q[ix]);
		t2 = p[63:0];
		if (!nd_q) begin
			hm = t1_q + t2;
			hn = 1'b0;
		end else if (t2 >= t1_q) begin
			hm = t2 - t1_q;
			hn = 1'b1;
		end else begin
			hm = t1_q - t2;
			hn = 1'b0;
		end
		c_hess = clip_mag(hm[63], {hm[62:0], 1'b0}, hn);
		vf = force_q[vir_f(idx_q)];
		vxi = vir_x(idx_q);
		vmag = vf[63] ? (64'd0 - vf) : vf;
		c_vir = clip_mag(|p[127:80], p[79:16], vf[63] != nx_q[vxi]);
		a_vir = sat_add(vsum_q[idx_q], c_vir.val);
	end

	// requests to the shared unit
	always_comb begin
		alu_req = '0;
		case (state_q)
			ST_SQ_I: begin
				alu_req = '{1'b1, OP_MUL, {96'd0, mx_q[ix]}, {32'd0, mx_q[ix]}};
			end
			ST_RT_I: begin
				alu_req = '{1'b1, OP_SQRT, {64'd0, s_q}, 64'd0};
			end
			ST_KMD_I: begin
				alu_req = '{1'b1, OP_MUL, {96'd0, k_q}, {32'd0, md_q}};
			end
			ST_EN_I: begin
				alu_req = '{1'b1, OP_MUL, {64'd0, kmd_q}, {32'd0, md_q}};
			end
			ST_DE_I: begin
				alu_req = '{1'b1, OP_DIV, {47'd0, kmd_q, 17'd0}, {32'd0, r_q}};
			end
			ST_FM_I: begin
				alu_req = '{1'b1, OP_MUL, {64'd0, kmd_q}, {32'd0, mx_q[ix]}};
			end
			ST_FD_I: begin
				alu_req = '{1'b1, OP_DIV, {prod_q[126:0], 1'b0}, {32'd0, r_q}};
			end
			ST_T1M_I: begin
				alu_req = '{1'b1, OP_MUL, {79'd0, k_q, 17'd0}, sq_q[ix]};
			end
			ST_T1D_I: begin
				alu_req = '{1'b1, OP_DIV, prod_q, s_q};
			end
			ST_T2M_I: begin
				alu_req = '{1'b1, OP_MUL, {64'd0, de_q}, s_q - sq_q[ix]};
			end
			ST_T2D_I: begin
				alu_req = '{1'b1, OP_DIV, prod_q, s_q};
			end
			ST_VM_I: begin
				alu_req = '{1'b1, OP_MUL, {64'd0, vmag}, {32'd0, mx_q[vxi]}};
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	// sequencer, configuration and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			energy_q <= '0;
			sums_clip_q <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				vsum_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				box_len_q[i] <= '0;
				box_half_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_BOX_LENGTH_X: box_len_q[0] <= cfg_data;
					REG_BOX_LENGTH_Y: box_len_q[1] <= cfg_data;
					REG_BOX_LENGTH_Z: box_len_q[2] <= cfg_data;
					REG_BOX_HALF_X:   box_half_q[0] <= cfg_data;
					REG_BOX_HALF_Y:   box_half_q[1] <= cfg_data;
					REG_BOX_HALF_Z:   box_half_q[2] <= cfg_data;
					default: ;
				endcase
			end

			// output register: load wins over a drain in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_valid) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP:  state_q <= ST_CLIP;
				ST_CLIP:  state_q <= ST_SQ_I;
				ST_SQ_I:  state_q <= ST_SQ_W;
				ST_SQ_W: begin
					if (alu_rsp.done) begin
						if (ix == 2'd2) begin
							idx_q <= '0;
							state_q <= ST_RT_I;
						end else begin
							idx_q <= idx_q + 3'd1;
							state_q <= ST_SQ_I;
						end
					end
				end
				ST_RT_I:  state_q <= ST_RT_W;
				ST_RT_W:  if (alu_rsp.done) state_q <= ST_KMD_I;
				ST_KMD_I: state_q <= ST_KMD_W;
				ST_KMD_W: if (alu_rsp.done) state_q <= ST_EN_I;
				ST_EN_I:  state_q <= ST_EN_W;
				ST_EN_W: begin
					if (alu_rsp.done) begin
						energy_q <= a_en.val;
						sums_clip_q <= sums_clip_q | a_en.sat;
						state_q <= (r_q == 32'd0) ? ST_OUT : ST_DE_I;
					end
				end
				ST_DE_I:  state_q <= ST_DE_W;
				ST_DE_W:  if (alu_rsp.done) state_q <= ST_FM_I;
				ST_FM_I:  state_q <= ST_FM_W;
				ST_FM_W:  if (alu_rsp.done) state_q <= ST_FD_I;
				ST_FD_I:  state_q <= ST_FD_W;
				ST_FD_W:  if (alu_rsp.done) state_q <= ST_T1M_I;
				ST_T1M_I: state_q <= ST_T1M_W;
				ST_T1M_W: if (alu_rsp.done) state_q <= ST_T1D_I;
				ST_T1D_I: state_q <= ST_T1D_W;
				ST_T1D_W: if (alu_rsp.done) state_q <= ST_T2M_I;
				ST_T2M_I: state_q <= ST_T2M_W;
				ST_T2M_W: if (alu_rsp.done) state_q <= ST_T2D_I;
				ST_T2D_I: state_q <= ST_T2D_W;
				ST_T2D_W: begin
					if (alu_rsp.done) begin
						if (ix == 2'd2) begin
							idx_q <= '0;
							state_q <= ST_VM_I;
						end else begin
							idx_q <= idx_q + 3'd1;
							state_q <= ST_FM_I;
						end
					end
				end
				ST_VM_I:  state_q <= ST_VM_W;
				ST_VM_W: begin
					if (alu_rsp.done) begin
						vsum_q[idx_q] <= a_vir.val;
						sums_clip_q <= sums_clip_q | a_vir.sat;
						if (idx_q == 3'd5) begin
							state_q <= ST_OUT;
						end else begin
							idx_q <= idx_q + 3'd1;
							state_q <= ST_VM_I;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= last_q ? ST_TOT : ST_IDLE;
					end
				end
				ST_TOT: begin
					if (out_free) begin
						energy_q <= '0;
						sums_clip_q <= 1'b0;
						for (int i = 0; i < 6; i++) begin
							vsum_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-bond datapath and output register
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					for (int i = 0; i < 3; i++) begin
						d_q[i] <= {{2{pb[i][31]}}, pb[i]} - {{2{pa[i][31]}}, pa[i]};
						force_q[i] <= '0;
						hess_q[i] <= '0;
					end
					k_q <= stiffness;
					req_q <= rest_length;
					last_q <= last_bond;
					sat_q <= 1'b0;
					s_q <= '0;
				end
			end
			ST_WRAP: begin
				for (int i = 0; i < 3; i++) begin
					d_q[i] <= dw[i];
				end
			end
			ST_CLIP: begin
				for (int i = 0; i < 3; i++) begin
					mx_q[i] <= mx_n[i];
					nx_q[i] <= nx_n[i];
				end
				sat_q <= sat_q | clip_sat;
			end
			ST_SQ_W: begin
				if (alu_rsp.done) begin
					sq_q[ix] <= p[63:0];
					s_q <= s_q + p[63:0];
				end
			end
			ST_RT_W: begin
				if (alu_rsp.done) begin
					r_q <= p[31:0];
					nd_q <= rt_diff[32];
					md_q <= rt_diff[32] ? rt_neg[31:0] : rt_diff[31:0];
				end
			end
			ST_KMD_W: if (alu_rsp.done) kmd_q <= p[63:0];
			ST_EN_W:  if (alu_rsp.done) sat_q <= sat_q | c_en.sat;
			ST_DE_W: begin
				if (alu_rsp.done) begin
					de_q <= c_de.val;
					sat_q <= sat_q | c_de.sat;
				end
			end
			ST_FM_W, ST_T1M_W, ST_T2M_W: begin
				if (alu_rsp.done) prod_q <= p;
			end
			ST_FD_W: begin
				if (alu_rsp.done) begin
					force_q[ix] <= c_force.val;
					sat_q <= sat_q | c_force.sat;
				end
			end
			ST_T1D_W: if (alu_rsp.done) t1_q <= p[63:0];
			ST_T2D_W: begin
				if (alu_rsp.done) begin
					hess_q[ix] <= c_hess.val;
					sat_q <= sat_q | c_hess.sat;
				end
			end
			ST_VM_W:  if (alu_rsp.done) sat_q <= sat_q | c_vir.sat;
			ST_OUT: begin
				if (out_free) begin
					kind_q <= 1'b0;
					val_q[0] <= force_q[0];
					val_q[1] <= force_q[1];
					val_q[2] <= force_q[2];
					val_q[3] <= hess_q[0];
					val_q[4] <= hess_q[1];
					val_q[5] <= hess_q[2];
					val_q[6] <= '0;
					last_res_q <= !last_q;
					sat_out_q <= sat_q;
				end
			end
			ST_TOT: begin
				if (out_free) begin
					kind_q <= 1'b1;
					val_q[0] <= energy_q;
					for (int i = 0; i < 6; i++) begin
						val_q[i + 1] <= vsum_q[i];
					end
					last_res_q <= 1'b1;
					sat_out_q <= sums_clip_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign value_0 = val_q[0];
	assign value_1 = val_q[1];
	assign value_2 = val_q[2];
	assign value_3 = val_q[3];
	assign value_4 = val_q[4];
	assign value_5 = val_q[5];
	assign value_6 = val_q[6];
	assign last_result = last_res_q;
	assign saturated = sat_out_q;

	// an accepted bond always starts with the wrap step
	a_accept_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_WRAP)
		else $error("accepted bond did not enter wrap step");

	// a totals item always closes the input's results
	a_totals_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind) |-> last_result)
		else $error("totals item without last_result");

	// emitting the totals clears the energy sum and the clip flag
	a_totals_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TOT && out_free) |=> (energy_q == 64'd0 && !sums_clip_q))
		else $error("sums not cleared after totals");

	// no new bond is taken while the shared unit reports a result
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> in_stall)
		else $error("shared unit finished while idle");

endmodule

`default_nettype wire

FILE: bench/harmonic_bond_force_top_tb.sv
`default_nettype none

module harmonic_bond_force_top_tb import hbf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		int          ax, ay, az, bx, by, bz;
		int unsigned k, req;
		bit          last;
		bit          zero_exp;
	} bond_t;

	typedef struct {
		bit          kind;
		logic [63:0] v [7];
		bit          last;
		bit          sat;
	} bond_result_t;

	logic               clk, arst_n;
	logic               cfg_wr_en;
	logic [2:0]         cfg_index;
	logic [30:0]        cfg_data;
	logic               in_valid, in_stall;
	logic signed [31:0] pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z;
	logic [31:0]        stiffness, rest_length;
	logic               last_bond;
	logic               out_valid, out_stall;
	logic               kind;
	logic signed [63:0] value_0, value_1, value_2, value_3, value_4, value_5, value_6;
	logic               last_result, saturated;

	harmonic_bond_force_top dut (.*);

	// shadow of the box registers and the running sums
	longint      box_len [3];
	longint      box_half [3];
	logic [63:0] energy_acc;
	logic [63:0] virial_acc [6];
	bit          sums_sat;

	bond_result_t bond_results_q [$];
	int n_errors, n_bonds, n_totals, n_phases;
	bit calm;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("harmonic_bond_force_top_tb: done, errors");
		$finish;
	end

	// magnitude and sign to 64-bit two's complement, saturating
	function automatic logic [63:0] clip_wide(input logic [127:0] m, input bit neg,
			inout bit sat);
		logic [63:0] lim, v;
		lim = neg ? SMIN_MAG : SMAX;
		v = m[63:0];
		if (m[127:64] != 0 || v > lim) begin
			v = lim;
			sat = 1;
		end
		return neg ? 64'd0 - v : v;
	endfunction

	// quotient; a quotient of 2^64 or more comes back as exactly 2^64
	function automatic logic [127:0] div_wide(input logic [127:0] a, input logic [63:0] d);
		if (a[127:64] >= d) begin
			return {64'd1, 64'd0};
		end
		return a / {64'd0, d};
	endfunction

	function automatic logic [63:0] acc_add(input logic [63:0] a, input logic [63:0] b,
			inout bit sat);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			sat = 1;
			s = a[63] ? SMIN_MAG : SMAX;
		end
		return s;
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint min_image(input int a, input int b, input int ax, inout bit sat);
		longint d;
		d = longint'(b) - longint'(a);
		if (d > box_half[ax]) d = d - box_len[ax];
		else if (d < -box_half[ax]) d = d + box_len[ax];
		if (d > 64'sd2147483647) begin
			d = 64'sd2147483647;
			sat = 1;
		end
		if (d < -64'sd2147483648) begin
			d = -64'sd2147483648;
			sat = 1;
		end
		return d;
	endfunction

	// computes the per-bond result, updates the sums, and the totals on the last bond
	function automatic int bond_force(input bond_t b, output bond_result_t br,
			output bond_result_t tot);
		int          fsel [6] = '{0, 1, 1, 2, 2, 2};
		int          xsel [6] = '{0, 0, 1, 0, 1, 2};
		longint      d [3];
		logic [63:0] mx [3], frc [3], hess [3];
		bit          nx [3];
		logic [63:0] s, r, md, e, de, sq, t1, t2, m, ks, mf, vir;
		logic [127:0] kd2, w;
		longint      dt;
		bit          sat, nd, desat, hn, vn;
		sat = 0;
		d[0] = min_image(b.ax, b.bx, 0, sat);
		d[1] = min_image(b.ay, b.by, 1, sat);
		d[2] = min_image(b.az, b.bz, 2, sat);
		s = 0;
		for (int i = 0; i < 3; i++) begin
			nx[i] = d[i] < 0;
			mx[i] = nx[i] ? -d[i] : d[i];
			s = s + mx[i] * mx[i];
			frc[i] = 0;
			hess[i] = 0;
		end
		r = floor_sqrt(s);
		dt = longint'(r) - longint'({32'd0, b.req});
		nd = dt < 0;
		md = nd ? -dt : dt;
		w = 128'(b.k) * 128'(md);
		e = clip_wide((w * 128'(md)) >> 16, 1'b0, sat);
		energy_acc = acc_add(energy_acc, e, sums_sat);
		if (r != 0) begin
			kd2 = w * 128'd2;
			desat = 0;
			de = clip_wide(div_wide(kd2 << 16, r), 1'b0, desat);
			if (desat) sat = 1;
			ks = {32'd0, b.k} << 17;
			for (int i = 0; i < 3; i++) begin
				sq = mx[i] * mx[i];
				t1 = 64'(div_wide(128'(ks) * 128'(sq), s));
				t2 = 64'(div_wide(128'(de) * 128'(s - sq), s));
				hn = 0;
				if (!nd) m = t1 + t2;
				else if (t2 >= t1) begin
					m = t2 - t1;
					hn = 1;
				end else m = t1 - t2;
				frc[i] = clip_wide(div_wide(kd2 * 128'(mx[i]), r), nd == nx[i], sat);
				hess[i] = clip_wide(128'(m) * 128'd2, hn, sat);
			end
			for (int i = 0; i < 6; i++) begin
				mf = frc[fsel[i]];
				vn = mf[63] != nx[xsel[i]];
				if (mf[63]) mf = 64'd0 - mf;
				vir = clip_wide((128'(mf) * 128'(mx[xsel[i]])) >> 16, vn, sat);
				virial_acc[i] = acc_add(virial_acc[i], vir, sums_sat);
			end
		end
		br.kind = 0;
		for (int i = 0; i < 3; i++) begin
			br.v[i] = frc[i];
			br.v[3 + i] = hess[i];
		end
		br.v[6] = 0;
		br.last = !b.last;
		br.sat = sat;
		tot = br;
		if (!b.last) return 1;
		tot.kind = 1;
		tot.v[0] = energy_acc;
		for (int i = 0; i < 6; i++) tot.v[1 + i] = virial_acc[i];
		tot.last = 1;
		tot.sat = sums_sat;
		energy_acc = 0;
		for (int i = 0; i < 6; i++) virial_acc[i] = 0;
		sums_sat = 0;
		return 2;
	endfunction

	function automatic int pick_gap();
		int x;
		if (calm) return 0;
		x = $urandom_range(0, 99);
		if (x < 55) return 0;
		if (x < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// output stall: random stretches
	initial begin
		int hold;
		out_stall = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) hold--;
			else begin
				out_stall = calm ? 1'b0 : ($urandom_range(0, 2) == 0);
				hold = pick_gap();
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		bond_result_t ex;
		logic [63:0]  act [7];
		if (arst_n && out_valid && !out_stall) begin
			act = '{value_0, value_1, value_2, value_3, value_4, value_5, value_6};
			if (bond_results_q.size() == 0) begin
				$display("%0t: unexpected item, kind %0d", $realtime, kind);
				n_errors++;
			end else begin
				ex = bond_results_q.pop_front();
				if (kind !== ex.kind) begin
					$display("%0t: kind exp %0d got %0d", $realtime, ex.kind, kind);
					n_errors++;
				end
				for (int i = 0; i < 7; i++) begin
					if (act[i] !== ex.v[i]) begin
						$display("%0t: value_%0d exp %h got %h", $realtime, i, ex.v[i], act[i]);
						n_errors++;
					end
				end
				if (last_result !== ex.last) begin
					$display("%0t: last_result exp %0d got %0d", $realtime, ex.last,
						last_result);
					n_errors++;
				end
				if (saturated !== ex.sat) begin
					$display("%0t: saturated exp %0d got %0d", $realtime, ex.sat, saturated);
					n_errors++;
				end
				if (ex.kind) n_totals++;
				else n_bonds++;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input longint val);
		cfg_wr_en = 1;
		cfg_index = idx;
		cfg_data = val[30:0];
		@(negedge clk);
		cfg_wr_en = 0;
		if (idx < 3) box_len[idx] = val;
		else box_half[idx - 3] = val;
	endtask

	task automatic set_box(input longint lx, ly, lz, hx, hy, hz);
		write_reg(REG_BOX_LENGTH_X, lx);
		write_reg(REG_BOX_LENGTH_Y, ly);
		write_reg(REG_BOX_LENGTH_Z, lz);
		write_reg(REG_BOX_HALF_X, hx);
		write_reg(REG_BOX_HALF_Y, hy);
		write_reg(REG_BOX_HALF_Z, hz);
	endtask

	// drive one bond and wait for it to be taken; entered and left at a falling edge
	task automatic send_bond(input bond_t b);
		int g;
		bond_result_t r0, r1;
		g = pick_gap();
		if (g > 0) begin
			in_valid = 0;
			repeat (g) @(negedge clk);
		end
		pos_a_x = b.ax; pos_a_y = b.ay; pos_a_z = b.az;
		pos_b_x = b.bx; pos_b_y = b.by; pos_b_z = b.bz;
		stiffness = b.k;
		rest_length = b.req;
		last_bond = b.last;
		in_valid = 1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		if (bond_force(b, r0, r1) == 2) begin
			bond_results_q.push_back(b.zero_exp ?
				bond_result_t'{0, '{default: 0}, 0, 0} : r0);
			bond_results_q.push_back(r1);
		end else begin
			bond_results_q.push_back(b.zero_exp ?
				bond_result_t'{0, '{default: 0}, 1, 0} : r0);
		end
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 0;
		while (bond_results_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic int coord();
		return $urandom_range(0, 1 << 27) - (1 << 26);
	endfunction

	function automatic int offset(input int ax);
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1 << 19) - (1 << 18);
			1: return $urandom_range(0, 1 << 23) - (1 << 22);
			2: return int'(box_len[ax]) + $urandom_range(0, 1 << 16) - (1 << 15);
			default: return int'(box_half[ax]) * ($urandom_range(0, 1) ? 1 : -1)
				+ $urandom_range(0, 2) - 1;
		endcase
	endfunction

	function automatic bond_t random_bond();
		bond_t b;
		int x;
		x = $urandom_range(0, 99);
		b.zero_exp = 0;
		b.last = ($urandom_range(0, 5) == 0);
		if (x < 15) begin
			// noise: every bit free
			b.ax = $urandom; b.ay = $urandom; b.az = $urandom;
			b.bx = $urandom; b.by = $urandom; b.bz = $urandom;
			b.k = $urandom; b.req = $urandom;
		end else begin
			b.ax = coord(); b.ay = coord(); b.az = coord();
			if (x < 25) begin
				b.bx = b.ax; b.by = b.ay; b.bz = b.az;
			end else begin
				b.bx = b.ax + offset(0);
				b.by = b.ay + offset(1);
				b.bz = b.az + offset(2);
			end
			b.k = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1 << 22);
			b.req = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1 << 22);
		end
		return b;
	endfunction

	// directed bonds, box registers at reset (no wrap)
	localparam int ONE = 1 << 16;
	bond_t directed [] = '{
		'{0, 0, 0, 0, 0, 0, 0, 0, 1, 1},
		'{5, 6, 7, 5, 6, 7, ONE, ONE, 1, 1},
		'{3, -3, 9, 3, -3, 9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0},
		'{32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, ONE, 0, 0, 0},
		'{32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, ONE, 0, 0, 0},
		'{0, 0, 0, ONE, 0, 0, ONE, ONE, 0, 0},
		'{0, 0, 0, ONE, 0, 0, ONE, 0, 0, 0},
		'{0, 0, 0, 0, 2 * ONE, 0, ONE, 3 * ONE, 0, 0},
		'{ONE, ONE, ONE, -ONE, -2 * ONE, -3 * ONE, 5 * ONE, ONE, 1, 0},
		'{0, 0, 0, 1, 1, 1, 32'hFFFF_FFFF, 0, 0, 0},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0},
		'{0, 0, 0, 0, 0, 7 * ONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0},
		'{-ONE, 0, 0, 0, -ONE, 0, 0, 32'hFFFF_FFFF, 1, 0},
		'{0, 0, 0, 3 * ONE, 4 * ONE, 0, 32'h00FF_0000, 5 * ONE, 1, 0}
	};

	initial begin
		longint l;
		arst_n = 0;
		cfg_wr_en = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0;
		pos_a_x = 0; pos_a_y = 0; pos_a_z = 0;
		pos_b_x = 0; pos_b_y = 0; pos_b_z = 0;
		stiffness = 0; rest_length = 0; last_bond = 0;
		calm = 0;
		n_errors = 0; n_bonds = 0; n_totals = 0; n_phases = 0;
		for (int i = 0; i < 3; i++) begin
			box_len[i] = 0;
			box_half[i] = 0;
		end
		energy_acc = 0;
		for (int i = 0; i < 6; i++) virial_acc[i] = 0;
		sums_sat = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (directed[i]) send_bond(directed[i]);

		// phases, each with its own box setting
		for (int p = 0; p < 7; p++) begin
			drain();
			case (p)
				0: ;
				1: set_box(20 * ONE, 30 * ONE, 40 * ONE, 10 * ONE, 15 * ONE, 20 * ONE);
				2: set_box(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
					31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
				3: set_box(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0);
				4: set_box($urandom_range(0, 31'h7FFF_FFFF), $urandom_range(0, 31'h7FFF_FFFF),
					$urandom_range(0, 31'h7FFF_FFFF), $urandom_range(0, 31'h7FFF_FFFF),
					$urandom_range(0, 31'h7FFF_FFFF), $urandom_range(0, 31'h7FFF_FFFF));
				5: set_box(10 * ONE, 10 * ONE, 10 * ONE, 5 * ONE, 5 * ONE, 5 * ONE);
				default: begin
					l = $urandom_range(1 << 20, 1 << 28);
					set_box(l, l + 3, l >> 1, l >> 1, (l + 3) >> 1, l >> 2);
				end
			endcase
			n_phases++;
			for (int i = 0; i < 115; i++) begin
				if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
				send_bond(random_bond());
			end
		end
		calm = 0;

		drain();
		repeat (600) @(negedge clk);
		if (bond_results_q.size() != 0) begin
			$display("%0t: %0d expected items never came", $realtime, bond_results_q.size());
			n_errors++;
		end
		$display("covered %0d bond items and %0d totals over %0d box settings, %0d mismatches",
			n_bonds, n_totals, n_phases, n_errors);
		if (n_errors == 0) begin
			$display("harmonic_bond_force_top_tb: done, clean");
		end else begin
			$display("harmonic_bond_force_top_tb: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/hbf_pkg.sv
rtl/core/hbf_alu.sv
rtl/core/harmonic_bond_force_top.sv
bench/harmonic_bond_force_top_tb.sv
